/* rtl/core/slr_table_token_parser_defines.svh */
// assertion macros shared by the parser rtl
`ifndef SLR_TABLE_TOKEN_PARSER_DEFINES_SVH
`define SLR_TABLE_TOKEN_PARSER_DEFINES_SVH

// same-cycle implication
`define SLR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slr_pkg.sv */
package slr_pkg;

    localparam int NUM_STATES = 49;
    localparam logic [4:0] END_TOKEN = 5'd19;

    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_SYNTAX   = 2'd1;
    localparam logic [1:0] CAUSE_OVERFLOW = 2'd2;

    // goto columns of the rule heads
    localparam logic [4:0] COL_QUEST = 5'd20;
    localparam logic [4:0] COL_OR    = 5'd21;
    localparam logic [4:0] COL_AND   = 5'd22;
    localparam logic [4:0] COL_REL   = 5'd23;
    localparam logic [4:0] COL_SUM   = 5'd24;
    localparam logic [4:0] COL_TERM  = 5'd25;
    localparam logic [4:0] COL_FACT  = 5'd26;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_GOTO = 4'b0100,
        ST_VERD = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        ACT_ERR   = 2'd0,
        ACT_SHIFT = 2'd1,
        ACT_ACC   = 2'd2,
        ACT_RED   = 2'd3
    } act_kind_t;

    typedef struct packed {
        act_kind_t  kind;
        logic [3:0] rule;
    } action_t;

    localparam logic [2:0] RULE_LEN [16] = '{
        3'd1, 3'd2, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd5
    };

    localparam logic [4:0] RULE_HEAD [16] = '{
        COL_FACT, COL_FACT, COL_FACT, COL_TERM, COL_TERM, COL_SUM, COL_SUM, COL_REL,
        COL_REL, COL_REL, COL_AND, COL_AND, COL_OR, COL_OR, COL_QUEST, COL_QUEST
    };

    // one row per state, first character is column 0
    localparam logic [159:0] ACT_ROWS [NUM_STATES] = '{
        ".........s..ss.ssss.", "...................a",
        "sOs...........O....O", "MMMs..........M....M",
        "KKKK..........K....K", "HHHHssssss....H....H",
        "FFFFFFFFFFss..F....F", "DDDDDDDDDDDD..D....D",
        ".........s..ss.ssss.", ".........s..ss.ssss.",
        ".........s..ss.ssss.", "AAAAAAAAAAAA..A....A",
        "AAAAAAAAAAAA..A....A", "AAAAAAAAAAAA..A....A",
        "AAAAAAAAAAAA..A....A", ".........s..ss.ssss.",
        ".........s..ss.ssss.", ".........s..ss.ssss.",
        ".........s..ss.ssss.", "....s...............",
        "....s...............", ".s..s....s..ss.ssss.",
        "....s....s..ss.ssss.", ".........s..ss.ssss.",
        ".........s..ss.ssss.", ".........s..ss.ssss.",
        "BBBBBBBBBBBB..B....B", "BBBBBBBBBBBB..B....B",
        "..............s.....", ".s..................",
        "NNNs..........N....N", "LLLL..........L....L",
        "GGGGGGGGGG....G....G", ".........s..ss.ssss.",
        ".........s..ss.ssss.", "IIII..........I....I",
        ".........s..ss.ssss.", "IIII..........I....I",
        ".........s..ss.ssss.", "GGGGGGGGGG....G....G",
        "EEEEEEEEEEEE..E....E", "EEEEEEEEEEEE..E....E",
        "CCCCCCCCCCCC..C....C", ".........s..ss.ssss.",
        "JJJJ..........J....J", "JJJJ..........J....J",
        "JJJJ..........J....J", "JJJJ..........J....J",
        ".P............P....P"
    };

    function automatic action_t lookup_action(logic [5:0] s, logic [4:0] tok);
        logic [159:0] row;
        logic [7:0]   ch;
        action_t      a;
        row = ACT_ROWS[s];
        ch = row[8 * (19 - int'(tok)) +: 8];
        a.kind = ACT_ERR;
        a.rule = 4'd0;
        if (ch == "s")
            a.kind = ACT_SHIFT;
        else if (ch == "a")
            a.kind = ACT_ACC;
        else if (ch >= "A" && ch <= "P")
        begin
            a.kind = ACT_RED;
            a.rule = 4'(ch - "A");
        end
        return a;
    endfunction

    // common shift targets for operand-start tokens
    function automatic logic [5:0] operand_shift(logic [4:0] tok);
        logic [5:0] t;
        case (tok)
            5'd9:    t = 6'd8;
            5'd12:   t = 6'd9;
            5'd13:   t = 6'd10;
            5'd15:   t = 6'd11;
            5'd16:   t = 6'd12;
            5'd17:   t = 6'd13;
            5'd18:   t = 6'd14;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] shift_target(logic [5:0] s, logic [4:0] tok);
        logic [5:0] t;
        t = 6'd0;
        case (s)
            6'd2:
            begin
                if (tok == 5'd0) t = 6'd15;
                if (tok == 5'd2) t = 6'd16;
            end
            6'd3, 6'd30: if (tok == 5'd3) t = 6'd17;
            6'd5:
            begin
                case (tok)
                    5'd4:    t = 6'd19;
                    5'd5:    t = 6'd20;
                    5'd6:    t = 6'd21;
                    5'd7:    t = 6'd22;
                    5'd8:    t = 6'd23;
                    5'd9:    t = 6'd18;
                    default: t = 6'd0;
                endcase
            end
            6'd6:
            begin
                if (tok == 5'd10) t = 6'd24;
                if (tok == 5'd11) t = 6'd25;
            end
            6'd19: if (tok == 5'd4) t = 6'd33;
            6'd20: if (tok == 5'd4) t = 6'd34;
            6'd28: if (tok == 5'd14) t = 6'd42;
            6'd29: if (tok == 5'd1) t = 6'd43;
            6'd21: t = (tok == 5'd4) ? 6'd36 : operand_shift(tok);
            6'd22: t = (tok == 5'd4) ? 6'd38 : operand_shift(tok);
            default: t = operand_shift(tok);
        endcase
        return t;
    endfunction

    function automatic logic [5:0] goto_target(logic [5:0] s, logic [4:0] col);
        logic [5:0] g;
        logic [5:0] sum_g;
        g = 6'd0;
        sum_g = 6'd0;
        case (s)
            6'd0, 6'd10, 6'd15, 6'd43:
            begin
                case (col)
                    COL_QUEST:
                    begin
                        case (s)
                            6'd0:    g = 6'd1;
                            6'd10:   g = 6'd28;
                            6'd15:   g = 6'd29;
                            default: g = 6'd48;
                        endcase
                    end
                    COL_OR:   g = 6'd2;
                    COL_AND:  g = 6'd3;
                    COL_REL:  g = 6'd4;
                    COL_SUM:  g = 6'd5;
                    COL_TERM: g = 6'd6;
                    COL_FACT: g = 6'd7;
                    default:  g = 6'd0;
                endcase
            end
            6'd8:  if (col == COL_FACT) g = 6'd26;
            6'd9:  if (col == COL_FACT) g = 6'd27;
            6'd24: if (col == COL_FACT) g = 6'd40;
            6'd25: if (col == COL_FACT) g = 6'd41;
            6'd16:
            begin
                case (col)
                    COL_AND:  g = 6'd30;
                    COL_REL:  g = 6'd4;
                    COL_SUM:  g = 6'd5;
                    COL_TERM: g = 6'd6;
                    COL_FACT: g = 6'd7;
                    default:  g = 6'd0;
                endcase
            end
            6'd17:
            begin
                case (col)
                    COL_REL:  g = 6'd31;
                    COL_SUM:  g = 6'd5;
                    COL_TERM: g = 6'd6;
                    COL_FACT: g = 6'd7;
                    default:  g = 6'd0;
                endcase
            end
            6'd18, 6'd23:
            begin
                if (col == COL_TERM) g = (s == 6'd18) ? 6'd32 : 6'd39;
                if (col == COL_FACT) g = 6'd7;
            end
            6'd21, 6'd22, 6'd33, 6'd34, 6'd36, 6'd38:
            begin
                case (s)
                    6'd21:   sum_g = 6'd35;
                    6'd22:   sum_g = 6'd37;
                    6'd33:   sum_g = 6'd44;
                    6'd34:   sum_g = 6'd45;
                    6'd36:   sum_g = 6'd46;
                    default: sum_g = 6'd47;
                endcase
                case (col)
                    COL_SUM:  g = sum_g;
                    COL_TERM: g = 6'd6;
                    COL_FACT: g = 6'd7;
                    default:  g = 6'd0;
                endcase
            end
            default: g = 6'd0;
        endcase
        return g;
    endfunction

endpackage

/* rtl/core/slr_stack.sv */
module slr_stack
    import slr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [5:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [5:0]    rd_data
);

    // states below the top of stack
    logic [5:0] mem [DEPTH];
    logic [5:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/slr_table_token_parser.sv */
// slr(1) expression recognizer: one token word per input handshake (codes 0..19, 19 = end
// marker). a shift is a table lookup, then idle for the next word; every reduction in
// front of it adds an action lookup with stack pop, then a registered stack read and
// goto. the registered read port of the stack memory puts the goto in its own state.
// accept or reject delivers one word (accepted, cause) and returns the stack to state 0;
// a code above 19, an error entry, a missing target or a short stack is a syntax error,
// a shift into a full stack is an overflow. no clearing pass: the stack is only read
// where it was pushed.
`include "slr_table_token_parser_defines.svh"

module slr_table_token_parser
    import slr_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] token,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic [1:0] cause
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int STW = $clog2(STACK_DEPTH + 1);

    state_t         state_reg, state_next;
    logic [4:0]     tok_reg, tok_next;
    logic [5:0]     top_reg, top_next;          // state on top of stack
    logic [STW-1:0] sp_reg, sp_next;            // entries held, top included
    logic [3:0]     rule_reg, rule_next;
    logic           vacc_reg, vacc_next;        // pending verdict
    logic [1:0]     vcause_reg, vcause_next;
    logic           out_valid_reg, out_valid_next;
    logic           acc_reg, acc_next;
    logic [1:0]     cause_reg, cause_next;

    action_t        act;
    logic [5:0]     shift_t;
    logic [5:0]     goto_t;
    logic [STW-1:0] rlen;
    logic [STW-1:0] new_sp;
    logic           out_free;

    // stack memory control
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [5:0]     rd_data;

    slr_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared table unit
    assign act     = lookup_action(top_reg, tok_reg);
    assign shift_t = shift_target(top_reg, tok_reg);
    assign goto_t  = goto_target(rd_data, RULE_HEAD[rule_reg]);
    assign rlen    = STW'(RULE_LEN[act.rule]);
    assign new_sp  = sp_reg - rlen;
    assign out_free = !out_valid_reg || !out_stall;

    assign wr_addr = sp_reg[AW-1:0] - AW'(1);
    assign rd_addr = new_sp[AW-1:0] - AW'(1);

    always_comb
    begin
        state_next     = state_reg;
        tok_next       = tok_reg;
        top_next       = top_reg;
        sp_next        = sp_reg;
        rule_next      = rule_reg;
        vacc_next      = vacc_reg;
        vcause_next    = vcause_reg;
        out_valid_next = out_valid_reg && out_stall;
        acc_next       = acc_reg;
        cause_next     = cause_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tok_next = token;
                    if (token > END_TOKEN)
                    begin
                        vacc_next   = 1'b0;
                        vcause_next = CAUSE_SYNTAX;
                        state_next  = ST_VERD;
                    end
                    else
                        state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next  = ST_VERD;
                vacc_next   = 1'b0;
                vcause_next = CAUSE_SYNTAX;
                unique case (act.kind)
                    ACT_ACC:
                    begin
                        vacc_next   = 1'b1;
                        vcause_next = CAUSE_NONE;
                    end
                    ACT_SHIFT:
                    begin
                        if (shift_t == 6'd0)
                            vcause_next = CAUSE_SYNTAX;
                        else if (sp_reg >= STW'(STACK_DEPTH))
                            vcause_next = CAUSE_OVERFLOW;
                        else
                        begin
                            // old top goes into memory, new state stays in the register
                            wr_en      = 1'b1;
                            top_next   = shift_t;
                            sp_next    = sp_reg + STW'(1);
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_RED:
                    begin
                        if (sp_reg > rlen)
                        begin
                            rd_en      = 1'b1;
                            rule_next  = act.rule;
                            sp_next    = new_sp;
                            state_next = ST_GOTO;
                        end
                    end
                    default:
                    begin
                        vcause_next = CAUSE_SYNTAX;
                    end
                endcase
            end
            ST_GOTO:
            begin
                // state uncovered by the pop is in rd_data
                if (goto_t == 6'd0)
                begin
                    vacc_next   = 1'b0;
                    vcause_next = CAUSE_SYNTAX;
                    state_next  = ST_VERD;
                end
                else
                begin
                    // goto state pushed above the uncovered one
                    top_next   = goto_t;
                    sp_next    = sp_reg + STW'(1);
                    state_next = ST_LOOK;
                end
            end
            ST_VERD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = vacc_reg;
                    cause_next     = vcause_reg;
                    top_next       = 6'd0;
                    sp_next        = STW'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= 6'd0;
            sp_reg        <= STW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg    <= tok_next;
        rule_reg   <= rule_next;
        vacc_reg   <= vacc_next;
        vcause_reg <= vcause_next;
        acc_reg    <= acc_next;
        cause_reg  <= cause_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accepted  = acc_reg;
    assign cause     = cause_reg;

    `SLR_ASSERT_SAME(a_sp_range, 1'b1, (sp_reg != '0) && (sp_reg <= STW'(STACK_DEPTH)), "stack count out of range")
    `SLR_ASSERT_SAME(a_acc_cause, out_valid && accepted, cause == CAUSE_NONE, "accept with a cause")
    `SLR_ASSERT_NEXT(a_verd_wait, (state_reg == ST_VERD) && out_valid && out_stall, state_reg == ST_VERD, "verdict dropped")
    `SLR_ASSERT_NEXT(a_verd_clear, (state_reg == ST_VERD) && out_free, (sp_reg == STW'(1)) && (top_reg == 6'd0), "stack not cleared")

endmodule

/* dv/slr_table_token_parser_tb.sv */
`default_nettype none

module slr_table_token_parser_tb;
    import slr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 64;
    localparam int N_RANDOM  = 1200;
    localparam int MAX_CYCLE = 400000;

    // recognizer tables, kept apart from the rtl package functions
    localparam string ACT_TEXT [NUM_STATES] = '{
        ".........s..ss.ssss.", "...................a",
        "sOs...........O....O", "MMMs..........M....M",
        "KKKK..........K....K", "HHHHssssss....H....H",
        "FFFFFFFFFFss..F....F", "DDDDDDDDDDDD..D....D",
        ".........s..ss.ssss.", ".........s..ss.ssss.",
        ".........s..ss.ssss.", "AAAAAAAAAAAA..A....A",
        "AAAAAAAAAAAA..A....A", "AAAAAAAAAAAA..A....A",
        "AAAAAAAAAAAA..A....A", ".........s..ss.ssss.",
        ".........s..ss.ssss.", ".........s..ss.ssss.",
        ".........s..ss.ssss.", "....s...............",
        "....s...............", ".s..s....s..ss.ssss.",
        "....s....s..ss.ssss.", ".........s..ss.ssss.",
        ".........s..ss.ssss.", ".........s..ss.ssss.",
        "BBBBBBBBBBBB..B....B", "BBBBBBBBBBBB..B....B",
        "..............s.....", ".s..................",
        "NNNs..........N....N", "LLLL..........L....L",
        "GGGGGGGGGG....G....G", ".........s..ss.ssss.",
        ".........s..ss.ssss.", "IIII..........I....I",
        ".........s..ss.ssss.", "IIII..........I....I",
        ".........s..ss.ssss.", "GGGGGGGGGG....G....G",
        "EEEEEEEEEEEE..E....E", "EEEEEEEEEEEE..E....E",
        "CCCCCCCCCCCC..C....C", ".........s..ss.ssss.",
        "JJJJ..........J....J", "JJJJ..........J....J",
        "JJJJ..........J....J", "JJJJ..........J....J",
        ".P............P....P"
    };
    localparam int POP_LEN [16] = '{1,2,3,1,3,1,3,1,3,4,1,3,1,3,1,5};
    localparam int HEAD_COL [16] = '{26,26,26,25,25,24,24,23,23,23,22,22,21,21,20,20};

    typedef struct packed {
        logic       accepted;
        logic [1:0] cause;
    } verdict_t;

    // ------------------------------------------------------------------
    // scoreboard: runs the recognizer on each token and queues verdicts
    // ------------------------------------------------------------------
    class verdict_board;
        logic [5:0] stk [DEPTH];
        int         depth_held;
        int         next_of [NUM_STATES][27];
        verdict_t   pending [$];
        int         errors;

        function new();
            int s;
            int c;
            int fs [19];
            fs = '{0,0,0,0,0,0,0,0,0,8,0,0,9,10,0,11,12,13,14};
            errors = 0;
            for (s = 0; s < NUM_STATES; s++)
                for (c = 0; c < 27; c++)
                    next_of[s][c] = 0;
            // operand-start rows share the same shift columns
            foreach (ACT_TEXT[s])
                if (ACT_TEXT[s] == ".........s..ss.ssss.")
                    for (c = 0; c < 19; c++)
                        next_of[s][c] = fs[c];
            next_of[0][20] = 1;  next_of[10][20] = 28;
            next_of[15][20] = 29; next_of[43][20] = 48;
            foreach (next_of[s])
                if (s == 0 || s == 10 || s == 15 || s == 43)
                begin
                    next_of[s][21] = 2; next_of[s][22] = 3; next_of[s][23] = 4;
                    next_of[s][24] = 5; next_of[s][25] = 6; next_of[s][26] = 7;
                end
            next_of[2][0] = 15; next_of[2][2] = 16;
            next_of[3][3] = 17; next_of[30][3] = 17;
            next_of[5][4] = 19; next_of[5][5] = 20; next_of[5][6] = 21;
            next_of[5][7] = 22; next_of[5][8] = 23; next_of[5][9] = 18;
            next_of[6][10] = 24; next_of[6][11] = 25;
            next_of[8][26] = 26; next_of[9][26] = 27;
            next_of[24][26] = 40; next_of[25][26] = 41;
            next_of[16][22] = 30; next_of[16][23] = 4; next_of[16][24] = 5;
            next_of[16][25] = 6; next_of[16][26] = 7;
            next_of[17][23] = 31; next_of[17][24] = 5; next_of[17][25] = 6;
            next_of[17][26] = 7;
            next_of[18][25] = 32; next_of[18][26] = 7;
            next_of[23][25] = 39; next_of[23][26] = 7;
            next_of[19][4] = 33; next_of[20][4] = 34;
            next_of[28][14] = 42; next_of[29][1] = 43;
            for (c = 0; c < 19; c++)
            begin
                next_of[21][c] = fs[c];
                next_of[22][c] = fs[c];
            end
            next_of[21][4] = 36; next_of[22][4] = 38;
            next_of[21][24] = 35; next_of[22][24] = 37; next_of[33][24] = 44;
            next_of[34][24] = 45; next_of[36][24] = 46; next_of[38][24] = 47;
            foreach (next_of[s])
                if (s == 21 || s == 22 || s == 33 || s == 34 || s == 36 || s == 38)
                begin
                    next_of[s][25] = 6;
                    next_of[s][26] = 7;
                end
            clear();
        endfunction

        function void clear();
            foreach (stk[i])
                stk[i] = '0;
            depth_held = 1;
        endfunction

        function void finish_sentence(logic acc, logic [1:0] why);
            verdict_t v;
            v.accepted = acc;
            v.cause = why;
            pending.push_back(v);
            clear();
        endfunction

        // one accepted token word
        function void take_token(logic [4:0] tok);
            int    s;
            int    r;
            int    g;
            byte   code;
            if (tok > END_TOKEN)
            begin
                finish_sentence(1'b0, CAUSE_SYNTAX);
                return;
            end
            forever
            begin
                s = stk[depth_held - 1];
                code = ACT_TEXT[s][tok];
                if (code == "a")
                begin
                    finish_sentence(1'b1, CAUSE_NONE);
                    return;
                end
                if (code == "s")
                begin
                    g = next_of[s][tok];
                    if (g == 0)
                        finish_sentence(1'b0, CAUSE_SYNTAX);
                    else if (depth_held >= DEPTH)
                        finish_sentence(1'b0, CAUSE_OVERFLOW);
                    else
                    begin
                        stk[depth_held] = 6'(g);
                        depth_held++;
                    end
                    return;
                end
                if (code < "A" || code > "P")
                begin
                    finish_sentence(1'b0, CAUSE_SYNTAX);
                    return;
                end
                r = code - "A";
                if (depth_held <= POP_LEN[r])
                begin
                    finish_sentence(1'b0, CAUSE_SYNTAX);
                    return;
                end
                depth_held -= POP_LEN[r];
                g = next_of[stk[depth_held - 1]][HEAD_COL[r]];
                if (g == 0)
                begin
                    finish_sentence(1'b0, CAUSE_SYNTAX);
                    return;
                end
                stk[depth_held] = 6'(g);
                depth_held++;
            end
        endfunction

        function void check_verdict(logic acc, logic [1:0] why);
            verdict_t want;
            if (pending.size() == 0)
            begin
                $error("verdict with none expected: accepted=%0d cause=%0d", acc, why);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (acc !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, acc);
                errors++;
            end
            if (why !== want.cause)
            begin
                $error("cause: expected %0d, got %0d", want.cause, why);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [4:0] token;
    logic       out_valid;
    logic       out_stall;
    logic       accepted;
    logic [1:0] cause;

    verdict_board board;
    bit           calm;       // no idling on either side while set
    bit           feed_done;
    int           cycle_count;

    slr_table_token_parser #(.STACK_DEPTH(DEPTH)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .token     (token),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .accepted  (accepted),
        .cause     (cause)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // token codes used by the sentence builder
    localparam logic [4:0] T_QUEST = 5'd0,  T_COLON = 5'd1,  T_OR   = 5'd2,  T_AND = 5'd3;
    localparam logic [4:0] T_EQ    = 5'd4,  T_BANG  = 5'd5,  T_LT   = 5'd6,  T_GT  = 5'd7;
    localparam logic [4:0] T_PLUS  = 5'd8,  T_MINUS = 5'd9,  T_MUL  = 5'd10, T_DIV = 5'd11;
    localparam logic [4:0] T_NOT   = 5'd12, T_LPAR  = 5'd13, T_RPAR = 5'd14, T_NUM = 5'd15;
    localparam logic [4:0] T_ID    = 5'd16, T_FALSE = 5'd17, T_TRUE = 5'd18;

    logic [4:0] sentence [$];

    // random well-formed expression, depth-bounded
    task automatic gen_fact(int lvl);
        int k;
        k = (lvl > 6) ? $urandom_range(0, 3) : $urandom_range(0, 6);
        case (k)
            0: sentence.push_back(T_NUM);
            1: sentence.push_back(T_ID);
            2: sentence.push_back(T_FALSE);
            3: sentence.push_back(T_TRUE);
            4:
            begin
                sentence.push_back(T_MINUS);
                gen_fact(lvl + 1);
            end
            5:
            begin
                sentence.push_back(T_NOT);
                gen_fact(lvl + 1);
            end
            default:
            begin
                sentence.push_back(T_LPAR);
                gen_expr(lvl + 1);
                sentence.push_back(T_RPAR);
            end
        endcase
    endtask

    task automatic gen_expr(int lvl);
        int n;
        int k;
        n = (lvl > 4) ? 0 : $urandom_range(0, 3);
        gen_fact(lvl);
        repeat (n)
        begin
            k = $urandom_range(0, 12);
            case (k)
                0: sentence.push_back(T_PLUS);
                1: sentence.push_back(T_MINUS);
                2: sentence.push_back(T_MUL);
                3: sentence.push_back(T_DIV);
                4: sentence.push_back(T_LT);
                5: sentence.push_back(T_GT);
                6:
                begin
                    sentence.push_back(T_LT);
                    sentence.push_back(T_EQ);
                end
                7:
                begin
                    sentence.push_back(T_BANG);
                    sentence.push_back(T_EQ);
                end
                8:
                begin
                    sentence.push_back(T_EQ);
                    sentence.push_back(T_EQ);
                end
                9:  sentence.push_back(T_AND);
                10: sentence.push_back(T_OR);
                default:
                begin
                    sentence.push_back(T_QUEST);
                    gen_expr(lvl + 1);
                    sentence.push_back(T_COLON);
                end
            endcase
            gen_fact(lvl);
        end
    endtask

    // one token word through the input handshake; valid stays up for a following word
    task automatic send_token(logic [4:0] tok);
        if (!calm && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (!calm && $urandom_range(0, 99) < 23)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        token <= tok;
        do
            @(posedge clk);
        while (in_stall);
        board.take_token(tok);
        @(negedge clk);
    endtask

    task automatic send_sentence();
        foreach (sentence[i])
            send_token(sentence[i]);
        sentence.delete();
    endtask

    // receiver stall pattern
    always @(negedge clk)
        if (rst_n)
            out_stall <= !calm && ($urandom_range(0, 99) < 23);

    // output sampled at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(accepted, cause);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int  n;
        int  k;
        int  tail;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        token = '0;
        out_stall = 1'b0;
        calm = 1'b0;
        feed_done = 1'b0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: accepted sentences touching every operator
        sentence = '{T_NUM, 5'd19};
        send_sentence();
        sentence = '{T_NOT, T_LPAR, T_ID, T_QUEST, T_TRUE, T_COLON, T_FALSE, T_RPAR,
                     T_OR, T_MINUS, T_NUM, T_AND, T_ID, T_LT, T_EQ, T_NUM, 5'd19};
        send_sentence();
        sentence = '{T_NUM, T_BANG, T_EQ, T_ID, T_PLUS, T_NUM, T_MUL, T_ID, T_DIV, T_NUM,
                     T_GT, T_EQ, T_NUM, T_EQ, T_EQ, T_ID, 5'd19};
        send_sentence();
        // syntax error entry, bare end marker, out-of-range codes, doubled operator
        send_token(T_RPAR);
        send_token(5'd19);
        send_token(5'd31);
        send_token(5'd20);
        sentence = '{T_NUM, T_GT, T_GT};
        send_sentence();
        // overflow: nest parens past the stack depth
        repeat (DEPTH) send_token(T_LPAR);

        // random: mostly well-formed sentences, with a calm stretch in the middle
        n = 0;
        while (n < N_RANDOM)
        begin
            calm = (n > N_RANDOM / 3) && (n < N_RANDOM / 2);
            k = $urandom_range(0, 99);
            if (k < 70)
            begin
                gen_expr(0);
                sentence.push_back(5'd19);
            end
            else if (k < 85)
            begin
                // broken: one token replaced with a random code
                gen_expr(0);
                sentence.push_back(5'd19);
                sentence[$urandom_range(0, sentence.size() - 1)] = 5'($urandom_range(0, 19));
            end
            else if (k < 95)
            begin
                repeat ($urandom_range(1, 6))
                    sentence.push_back(5'($urandom_range(0, 31)));
                sentence.push_back(5'd19);
            end
            else
            begin
                // deep nesting near the stack limit
                repeat ($urandom_range(DEPTH - 8, DEPTH + 2))
                    sentence.push_back(T_LPAR);
                sentence.push_back(T_NUM);
                sentence.push_back(5'd19);
            end
            n += sentence.size();
            send_sentence();
        end
        calm = 1'b0;
        // leave the stack back at state 0
        send_token(5'd31);
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 200)
        begin
            @(posedge clk);
            tail++;
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/slr_pkg.sv
rtl/core/slr_stack.sv
rtl/core/slr_table_token_parser.sv
dv/slr_table_token_parser_tb.sv
